/* rtl/gnp_pkg.sv */
`default_nettype none

package gnp_pkg;

  localparam int unsigned GEN_W     = 31;
  localparam int unsigned FRAC_BITS = 27;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned LVL_W     = 8;

  // Linear congruential generator, modulo 2^31.
  localparam logic [GEN_W-1:0] LCG_MUL = 31'd1103515245;
  localparam logic [GEN_W-1:0] LCG_ADD = 31'd12345;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_SEED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_EN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW       = 3'd5;

  // Reset values.
  localparam logic [GEN_W-1:0] SEED_RST      = 31'd1;
  localparam logic [GEN_W-1:0] GEN_RST       = 31'd1;
  localparam logic [LVL_W-1:0] AMPLITUDE_RST = 8'd30;
  localparam logic             THR_EN_RST    = 1'b0;
  localparam logic [LVL_W-1:0] THR_LEVEL_RST = 8'd128;
  localparam logic [LVL_W-1:0] HIGH_RST      = 8'd255;
  localparam logic [LVL_W-1:0] LOW_RST       = 8'd0;

endpackage

`default_nettype wire

/* rtl/gaussian_noise_pixel.sv */
// Channel  Direction  Handshake                 Word
// in       sink       in_valid_i / in_ready_o   base_pixel_i, restart_i
// out      source     out_valid_o / out_ready_i pixel_o
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// From acceptance to the output register a pixel passes through one generator
// step per term through the 31-bit multiplier, then the last sum add, the
// amplitude multiply, the noise shift and the clamp.
// The input is not ready while a pixel is in work; it is ready again as soon
// as the result sits in the output register, even if that word is not taken.
// A stalled output holds the block in its final cycle. Reset is asynchronous
// and active low; the configuration port is always ready.
`default_nettype none

module gaussian_noise_pixel #(
  parameter int unsigned SUM_TERMS = 12
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [gnp_pkg::PIX_W-1:0]      base_pixel_i,
  input  wire logic                           restart_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [gnp_pkg::PIX_W-1:0]           pixel_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [gnp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [gnp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned GEN_W   = gnp_pkg::GEN_W;
  localparam int unsigned FRAC    = gnp_pkg::FRAC_BITS;
  localparam int unsigned PIX_W   = gnp_pkg::PIX_W;
  localparam int unsigned LVL_W   = gnp_pkg::LVL_W;
  localparam int unsigned TERM_W  = GEN_W - 4;
  localparam int unsigned CNT_W   = $clog2(SUM_TERMS + 1);
  localparam int unsigned SUM_W   = FRAC + $clog2(SUM_TERMS + 1);
  localparam int unsigned DIFF_W  = SUM_W + 1;
  localparam int unsigned PROD_W  = DIFF_W + LVL_W + 1;
  localparam int unsigned NOISE_W = PROD_W - FRAC;
  localparam int unsigned M_W     = NOISE_W + 1;

  localparam logic [SUM_W-1:0]  CENTRE   = SUM_W'(SUM_TERMS * (2 ** (FRAC - 1)));
  localparam logic [PROD_W-1:0] BIAS     = PROD_W'((2 ** FRAC) - 1);
  localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(SUM_TERMS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STEP  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_NOISE = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [GEN_W-1:0]   gen_q, gen_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [NOISE_W-1:0] noise_q, noise_d;
  logic [PIX_W-1:0]   base_q, base_d;
  logic               out_valid_q, out_valid_d;
  logic [PIX_W-1:0]   pixel_q, pixel_d;

  logic [GEN_W-1:0]   seed_q;
  logic [LVL_W-1:0]   amp_q;
  logic               thr_en_q;
  logic [LVL_W-1:0]   thr_lvl_q;
  logic [LVL_W-1:0]   high_q;
  logic [LVL_W-1:0]   low_q;

  logic [GEN_W-1:0]   lcg_next;
  logic [SUM_W-1:0]   sum_acc;
  logic [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0] diff_ext;
  logic signed [LVL_W:0]    amp_ext;
  logic [PROD_W-1:0]  prod_biased;
  logic [M_W-1:0]     mixed;
  logic [PIX_W-1:0]   clamped;
  logic [PIX_W-1:0]   result;
  logic               in_acc, out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign pixel_o     = pixel_q;
  assign cfg_ready_o = 1'b1;

  // The generator multiplier: the product keeps only the low 31 bits.
  assign lcg_next = gen_q * gnp_pkg::LCG_MUL + gnp_pkg::LCG_ADD;
  assign sum_acc  = sum_q + SUM_W'(gen_q[GEN_W-1:GEN_W-TERM_W]);

  assign diff     = {1'b0, sum_q} - {1'b0, CENTRE};
  assign diff_ext = diff;
  assign amp_ext  = {1'b0, amp_q};

  // Division by 2^27 truncating toward zero: bias negative products first.
  assign prod_biased = prod_q + (prod_q[PROD_W-1] ? BIAS : '0);

  assign mixed = {noise_q[NOISE_W-1], noise_q} + {{(M_W-PIX_W){1'b0}}, base_q};

  always_comb begin
    if (mixed[M_W-1]) begin
      clamped = '0;
    end else if (|mixed[M_W-2:PIX_W]) begin
      clamped = '1;
    end else begin
      clamped = mixed[PIX_W-1:0];
    end
    if (thr_en_q) begin
      result = (clamped >= thr_lvl_q) ? high_q : low_q;
    end else begin
      result = clamped;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    gen_d       = gen_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    noise_d     = noise_q;
    base_d      = base_q;
    pixel_d     = pixel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          base_d  = base_pixel_i;
          gen_d   = restart_i ? seed_q : gen_q;
          sum_d   = '0;
          cnt_d   = '0;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        // The sum adds the registered generator word, so it trails the generator; the first step adds nothing.
        gen_d = lcg_next;
        if (cnt_q != '0) begin
          sum_d = sum_acc;
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == LAST_CNT) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        sum_d   = sum_acc;
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = PROD_W'(diff_ext * amp_ext);
        state_d = S_NOISE;
      end
      S_NOISE: begin
        noise_d = prod_biased[PROD_W-1:FRAC];
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          pixel_d     = result;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      gen_q       <= gnp_pkg::GEN_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    prod_q  <= prod_d;
    noise_q <= noise_d;
    base_q  <= base_d;
    pixel_q <= pixel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= gnp_pkg::SEED_RST;
      amp_q     <= gnp_pkg::AMPLITUDE_RST;
      thr_en_q  <= gnp_pkg::THR_EN_RST;
      thr_lvl_q <= gnp_pkg::THR_LEVEL_RST;
      high_q    <= gnp_pkg::HIGH_RST;
      low_q     <= gnp_pkg::LOW_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gnp_pkg::REG_SEED:      seed_q    <= cfg_data_i[GEN_W-1:0];
        gnp_pkg::REG_AMPLITUDE: amp_q     <= cfg_data_i[LVL_W-1:0];
        gnp_pkg::REG_THR_EN:    thr_en_q  <= cfg_data_i[0];
        gnp_pkg::REG_THR_LEVEL: thr_lvl_q <= cfg_data_i[LVL_W-1:0];
        gnp_pkg::REG_HIGH:      high_q    <= cfg_data_i[LVL_W-1:0];
        gnp_pkg::REG_LOW:       low_q     <= cfg_data_i[LVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/gnp_checker.sv */
`default_nettype none

module gnp_checker #(
  parameter int unsigned SUM_TERMS = 12
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [gnp_pkg::PIX_W-1:0] pixel_o
);

  // A stalled word stays on the output unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_o))
    else $error("output word changed or dropped while stalled");

  // The input closes once a pixel is accepted and is still closed at the end of its work.
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready after a pixel was accepted");

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##(SUM_TERMS + 4) !in_ready_o)
    else $error("input ready before the pixel's work was done");

  // A new word appears only at the end of a pixel's work.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("output word raised without a pixel in work");

endmodule

bind gaussian_noise_pixel gnp_checker #(
  .SUM_TERMS(SUM_TERMS)
) u_gnp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pixel_o     (pixel_o)
);

`default_nettype wire

/* dv/gaussian_noise_pixel_tb.sv */
`timescale 1ns / 100ps

// Holds the register copies and the generator state, works out the pixel that each
// accepted input word should produce, and keeps those pixels in arrival order.
class noisy_pixel_board;
  localparam int TERMS = 12;

  bit [30:0] seed;
  bit [30:0] generator;
  bit [7:0]  amplitude;
  bit        thr_enable;
  bit [7:0]  thr_level;
  bit [7:0]  high_level;
  bit [7:0]  low_level;

  bit [7:0]  due_pixels[$];
  int        errors;

  function new();
    seed       = 31'd1;
    generator  = 31'd1;
    amplitude  = 8'd30;
    thr_enable = 1'b0;
    thr_level  = 8'd128;
    high_level = 8'd255;
    low_level  = 8'd0;
    errors     = 0;
  endfunction

  function int pending();
    return due_pixels.size();
  endfunction

  task report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function void write_reg(input logic [gnp_pkg::CFG_IDX_W-1:0] idx,
                          input logic [gnp_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      gnp_pkg::REG_SEED:      seed       = data[30:0];
      gnp_pkg::REG_AMPLITUDE: amplitude  = data[7:0];
      gnp_pkg::REG_THR_EN:    thr_enable = data[0];
      gnp_pkg::REG_THR_LEVEL: thr_level  = data[7:0];
      gnp_pkg::REG_HIGH:      high_level = data[7:0];
      gnp_pkg::REG_LOW:       low_level  = data[7:0];
      default: ;
    endcase
  endfunction

  function void take_pixel(input bit [7:0] base, input bit restart);
    longint sum;
    longint diff;
    longint noise;
    longint level;
    bit [7:0] result;
    int k;
    if (restart) generator = seed;
    sum = 0;
    for (k = 0; k < TERMS; k++) begin
      // The product is taken at 31 bits, which gives the modulo 2^31 for free.
      generator = generator * 31'd1103515245 + 31'd12345;
      sum = sum + longint'(generator[30:4]);
    end
    diff  = sum - (longint'(TERMS) <<< 26);
    // Signed division truncates toward zero, as the noise definition requires.
    noise = (longint'(amplitude) * diff) / longint'(134217728);
    level = noise + longint'(base);
    if (level < 0) level = 0;
    else if (level > 255) level = 255;
    result = level[7:0];
    if (thr_enable) result = (result >= thr_level) ? high_level : low_level;
    due_pixels.push_back(result);
  endfunction

  task check_pixel(input logic [7:0] got);
    bit [7:0] want;
    if (due_pixels.size() == 0) begin
      report($sformatf("pixel %0h arrived with none due", got));
    end else begin
      want = due_pixels.pop_front();
      if (got !== want) report($sformatf("pixel got %0h, want %0h", got, want));
    end
  endtask
endclass

module gaussian_noise_pixel_tb;

  localparam logic [gnp_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [gnp_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;
  localparam int PIXEL_TARGET = 1750;
  localparam int CALM_FROM    = 1600;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [gnp_pkg::PIX_W-1:0]      base_pixel_i;
  logic                           restart_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [gnp_pkg::PIX_W-1:0]      pixel_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [gnp_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [gnp_pkg::CFG_DATA_W-1:0] cfg_data_i;

  noisy_pixel_board pixels = new();

  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int sent          = 0;

  gaussian_noise_pixel dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .base_pixel_i (base_pixel_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_o      (pixel_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // All three channels are observed in one place, at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) pixels.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) pixels.take_pixel(base_pixel_i, restart_i);
      if (out_valid_o && out_ready_i) pixels.check_pixel(pixel_o);
    end
  end

  // Receiver: stalls in bursts, at a rate the stimulus sets per phase.
  initial begin
    int n;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_stall_pct != 0 && $urandom_range(1, 100) <= out_stall_pct) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_reg(input logic [gnp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gnp_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pixel(input bit [7:0] base, input bit restart);
    int gap;
    if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    base_pixel_i <= base;
    restart_i    <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // Stops sending and waits until every due pixel has been taken.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pixels.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [gnp_pkg::CFG_DATA_W-1:0] pick_reg_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return gnp_pkg::CFG_DATA_W'($urandom_range(0, 40));
      4:       return gnp_pkg::CFG_DATA_W'($urandom_range(100, 255));
      default: return gnp_pkg::CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 40;
      default: return 70;
    endcase
  endfunction

  initial begin
    int phase;
    int burst;
    int i;
    int guard;
    bit [7:0] base;
    bit restart;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    base_pixel_i = '0;
    restart_i    = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values, then the edges of the pixel range.
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b1);
    send_pixel(8'd37, 1'b0);
    drain();

    // With no amplitude the pixel must come through untouched.
    write_reg(gnp_pkg::REG_AMPLITUDE, '0);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd91, 1'b0);
    drain();

    // Over-wide data keeps only the low bits; full amplitude exercises the clamps.
    write_reg(gnp_pkg::REG_AMPLITUDE, '1);
    write_reg(gnp_pkg::REG_SEED, '1);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd128, 1'b1);
    drain();

    write_reg(gnp_pkg::REG_SEED, '0);
    write_reg(gnp_pkg::REG_THR_EN, gnp_pkg::CFG_DATA_W'(3));
    write_reg(gnp_pkg::REG_THR_LEVEL, '0);
    send_pixel(8'd5, 1'b1);
    drain();
    write_reg(gnp_pkg::REG_THR_LEVEL, gnp_pkg::CFG_DATA_W'(255));
    write_reg(gnp_pkg::REG_HIGH, gnp_pkg::CFG_DATA_W'(8'h5a));
    write_reg(gnp_pkg::REG_LOW, gnp_pkg::CFG_DATA_W'(8'ha5));
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd200, 1'b0);
    drain();
    write_reg(gnp_pkg::REG_AMPLITUDE, gnp_pkg::CFG_DATA_W'(30));
    write_reg(gnp_pkg::REG_THR_LEVEL, gnp_pkg::CFG_DATA_W'(128));
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd127, 1'b0);
    send_pixel(8'd129, 1'b1);
    drain();

    // Writes to indexes past the last register must change nothing.
    write_reg(REG_UNUSED_A, '1);
    write_reg(REG_UNUSED_B, gnp_pkg::CFG_DATA_W'(1));
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd60, 1'b1);
    drain();
    write_reg(gnp_pkg::REG_THR_EN, '0);

    phase = 0;
    while (sent < PIXEL_TARGET) begin
      drain();
      if (sent >= CALM_FROM) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = pick_pct();
        out_stall_pct = pick_pct();
      end
      if (phase % 5 == 0) begin
        write_reg(gnp_pkg::REG_SEED, pick_reg_value());
        write_reg(gnp_pkg::REG_AMPLITUDE, pick_reg_value());
        write_reg(gnp_pkg::REG_THR_EN, pick_reg_value());
        write_reg(gnp_pkg::REG_THR_LEVEL, pick_reg_value());
        write_reg(gnp_pkg::REG_HIGH, pick_reg_value());
        write_reg(gnp_pkg::REG_LOW, pick_reg_value());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          write_reg(gnp_pkg::CFG_IDX_W'($urandom_range(0, 7)), pick_reg_value());
        end
      end
      burst = $urandom_range(10, 60);
      for (i = 0; i < burst; i++) begin
        case ($urandom_range(0, 9))
          0:       base = 8'd0;
          1:       base = 8'd255;
          default: base = 8'($urandom);
        endcase
        restart = (i == 0) ? 1'($urandom) : ($urandom_range(0, 31) == 0);
        send_pixel(base, restart);
      end
      phase++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    guard = 0;
    while (pixels.pending() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pixels.pending() != 0) begin
      pixels.report($sformatf("%0d pixels never arrived", pixels.pending()));
    end
    repeat (30) @(posedge clk_i);

    if (pixels.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/gnp_pkg.sv
rtl/gaussian_noise_pixel.sv
rtl/gnp_checker.sv
dv/gaussian_noise_pixel_tb.sv
